>>> hw/rtl/tsc_pkg.sv
package tsc_pkg;

  localparam int TSC_FRAC_BITS      = 16;
  localparam int TSC_ANGLE_INT_BITS = 4;

  // working precision of the polynomial datapath
  localparam int TSC_WBITS = 28;
  localparam int TSC_XW    = 31;  // wrapped angle, |x| <= pi
  localparam int TSC_X2W   = 34;  // x^2 and the x^2*t terms
  localparam int TSC_TW    = 30;  // horner partial sums, |t| <= 1
  localparam int TSC_CW    = 28;  // reciprocal coefficients

  // registered stages from input to skid buffer, plus the two skid entries
  localparam int TSC_DEPTH = 14;

  localparam logic [63:0] TSC_PI_Q60 = 64'd3622009729038561421;
  localparam longint      TSC_ONE    = 64'sd1 <<< TSC_WBITS;

  localparam logic signed [TSC_CW-1:0] TSC_C72 = TSC_CW'((TSC_ONE + 36) / 72);
  localparam logic signed [TSC_CW-1:0] TSC_C42 = TSC_CW'((TSC_ONE + 21) / 42);
  localparam logic signed [TSC_CW-1:0] TSC_C20 = TSC_CW'((TSC_ONE + 10) / 20);
  localparam logic signed [TSC_CW-1:0] TSC_C6  = TSC_CW'((TSC_ONE + 3) / 6);

  function automatic logic [63:0] tsc_pi_fx(input int fb);
    return (TSC_PI_Q60 + (64'd1 << (59 - fb))) >> (60 - fb);
  endfunction

  function automatic logic [63:0] tsc_tau_fx(input int fb);
    return (TSC_PI_Q60 + (64'd1 << (58 - fb))) >> (59 - fb);
  endfunction

  function automatic logic [63:0] tsc_half_pi_fx(input int fb);
    return (TSC_PI_Q60 + (64'd1 << (60 - fb))) >> (61 - fb);
  endfunction

  // arithmetic right shift, rounded to nearest with ties away from zero
  function automatic logic signed [63:0] tsc_rnd(input logic signed [63:0] p, input int sh);
    logic signed [63:0] h;
    logic signed [63:0] n;
    h = 64'sd1 <<< (sh - 1);
    n = signed'({63'd0, p[63]});
    return (p + h - n) >>> sh;
  endfunction

endpackage

>>> hw/rtl/tsc_wrap.sv
module tsc_wrap
  import tsc_pkg::*;
#(
  parameter int FRAC_BITS      = TSC_FRAC_BITS,
  parameter int ANGLE_INT_BITS = TSC_ANGLE_INT_BITS,
  localparam int AW = 1 + ANGLE_INT_BITS + FRAC_BITS,
  localparam int XFW = FRAC_BITS + 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic                  in_kind,
  input  logic signed [AW-1:0]  in_angle,
  output logic                  out_valid,
  output logic signed [XFW-1:0] out_x
);

  localparam int EW = AW + 2;
  localparam logic signed [EW-1:0] PI_E   = EW'(tsc_pi_fx(FRAC_BITS));
  localparam logic signed [EW-1:0] TAU_E  = EW'(tsc_tau_fx(FRAC_BITS));
  localparam logic signed [EW-1:0] HALF_E = EW'(tsc_half_pi_fx(FRAC_BITS));

  logic                 v0_r;
  logic                 kind0_r;
  logic signed [AW-1:0] angle0_r;
  logic                 v1_r;
  logic signed [XFW-1:0] x1_r;
  logic signed [EW-1:0] x_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind0_r  <= in_kind;
      angle0_r <= in_angle;
      x1_r     <= x_nxt[XFW-1:0];
    end
  end

  // binary search for the number of whole turns, largest power first;
  // each step leaves the angle just outside the range, the last one brings it in
  always_comb begin
    logic signed [EW-1:0] step;
    x_nxt = EW'(angle0_r);
    if (kind0_r) begin
      x_nxt = x_nxt + HALF_E;
    end
    for (int j = ANGLE_INT_BITS - 2; j >= 0; j--) begin
      step = TAU_E <<< j;
      if (x_nxt > PI_E + step) begin
        x_nxt = x_nxt - step;
      end else if (x_nxt < -PI_E - step) begin
        x_nxt = x_nxt + step;
      end
    end
    if (x_nxt > PI_E) begin
      x_nxt = x_nxt - TAU_E;
    end else if (x_nxt < -PI_E) begin
      x_nxt = x_nxt + TAU_E;
    end
  end

  assign out_valid = v1_r;
  assign out_x     = x1_r;

endmodule

>>> hw/rtl/tsc_poly.sv
module tsc_poly
  import tsc_pkg::*;
#(
  parameter int FRAC_BITS = TSC_FRAC_BITS,
  localparam int XFW = FRAC_BITS + 3,
  localparam int OW  = FRAC_BITS + 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic signed [XFW-1:0] in_x,
  output logic                  out_valid,
  output logic signed [OW-1:0]  out_value
);

  localparam int SH = TSC_WBITS - FRAC_BITS;
  localparam logic signed [TSC_TW-1:0] ONE_T  = TSC_TW'(TSC_ONE);
  localparam logic signed [TSC_XW-1:0] SAT_HI = TSC_XW'((64'sd1 <<< (FRAC_BITS + 1)) - 1);
  localparam logic signed [TSC_XW-1:0] SAT_LO = -TSC_XW'(64'sd1 <<< (FRAC_BITS + 1));

  logic signed [TSC_XW-1:0] xin;

  logic                      v_r [1:10];
  logic signed [TSC_XW-1:0]  x_r [1:8];
  logic signed [TSC_X2W-1:0] x2_r [1:6];
  logic signed [TSC_TW-1:0]  t2_r, t4_r, t6_r, t8_r;
  logic signed [TSC_X2W-1:0] u3_r, u5_r, u7_r;
  logic signed [TSC_XW-1:0]  r9_r;
  logic signed [OW-1:0]      val10_r;

  logic signed [2*TSC_XW-1:0]         p1;
  logic signed [TSC_X2W+TSC_CW-1:0]   p2, p4, p6, p8;
  logic signed [TSC_X2W+TSC_TW-1:0]   p3, p5, p7;
  logic signed [TSC_XW+TSC_TW-1:0]    p9;
  logic signed [TSC_XW-1:0]           r10;

  logic signed [TSC_X2W-1:0] x2_nxt, u3_nxt, u5_nxt, u7_nxt;
  logic signed [TSC_TW-1:0]  t2_nxt, t4_nxt, t6_nxt, t8_nxt;
  logic signed [TSC_XW-1:0]  r9_nxt;
  logic signed [OW-1:0]      val10_nxt;

  assign xin = TSC_XW'(in_x) <<< SH;

  // horner evaluation, at most one multiplier per stage; the last stage rounds and saturates
  always_comb begin
    p1     = xin * xin;
    x2_nxt = TSC_X2W'(tsc_rnd(64'(p1), TSC_WBITS));
    p2     = x2_r[1] * TSC_C72;
    t2_nxt = ONE_T - TSC_TW'(tsc_rnd(64'(p2), TSC_WBITS));
    p3     = x2_r[2] * t2_r;
    u3_nxt = TSC_X2W'(tsc_rnd(64'(p3), TSC_WBITS));
    p4     = u3_r * TSC_C42;
    t4_nxt = ONE_T - TSC_TW'(tsc_rnd(64'(p4), TSC_WBITS));
    p5     = x2_r[4] * t4_r;
    u5_nxt = TSC_X2W'(tsc_rnd(64'(p5), TSC_WBITS));
    p6     = u5_r * TSC_C20;
    t6_nxt = ONE_T - TSC_TW'(tsc_rnd(64'(p6), TSC_WBITS));
    p7     = x2_r[6] * t6_r;
    u7_nxt = TSC_X2W'(tsc_rnd(64'(p7), TSC_WBITS));
    p8     = u7_r * TSC_C6;
    t8_nxt = ONE_T - TSC_TW'(tsc_rnd(64'(p8), TSC_WBITS));
    p9     = x_r[8] * t8_r;
    r9_nxt = TSC_XW'(tsc_rnd(64'(p9), TSC_WBITS));
    r10    = TSC_XW'(tsc_rnd(64'(r9_r), SH));
    if (r10 > SAT_HI) begin
      val10_nxt = OW'(SAT_HI);
    end else if (r10 < SAT_LO) begin
      val10_nxt = OW'(SAT_LO);
    end else begin
      val10_nxt = OW'(r10);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= 10; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[1] <= in_valid;
      for (int k = 2; k <= 10; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[1]  <= xin;
      x2_r[1] <= x2_nxt;
      for (int k = 2; k <= 8; k++) begin
        x_r[k] <= x_r[k-1];
      end
      for (int k = 2; k <= 6; k++) begin
        x2_r[k] <= x2_r[k-1];
      end
      t2_r    <= t2_nxt;
      u3_r    <= u3_nxt;
      t4_r    <= t4_nxt;
      u5_r    <= u5_nxt;
      t6_r    <= t6_nxt;
      u7_r    <= u7_nxt;
      t8_r    <= t8_nxt;
      r9_r    <= r9_nxt;
      val10_r <= val10_nxt;
    end
  end

  assign out_valid = v_r[10];
  assign out_value = val10_r;

endmodule

>>> hw/rtl/tsc_skid.sv
module tsc_skid #(
  parameter int W = 18
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic [W-1:0] in_data,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         main_v_r;
  logic [W-1:0] main_d_r;
  logic         sk_v_r;
  logic [W-1:0] sk_d_r;
  logic         push;

  assign push = in_valid && !sk_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      sk_v_r   <= 1'b0;
    end else if (!main_v_r || out_ready) begin
      if (sk_v_r) begin
        main_v_r <= 1'b1;
        sk_v_r   <= 1'b0;
      end else begin
        main_v_r <= push;
      end
    end else if (push) begin
      // output stalled: park the request in the spare entry
      sk_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v_r || out_ready) begin
      main_d_r <= sk_v_r ? sk_d_r : in_data;
    end else if (push) begin
      sk_d_r <= in_data;
    end
  end

  assign in_ready  = !sk_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

endmodule

>>> hw/rtl/taylor_sine_cosine_unit.sv
// Sine or cosine of a signed fixed-point angle in radians by a degree-9 odd Taylor
// polynomial, one request per cycle. Cosine adds pi/2 first; the angle is then folded
// into [-pi, pi] by whole turns and the polynomial is evaluated in Horner form at 28
// fraction bits, the result rounded and saturated to a signed Q1.FRAC_BITS value.
// The path from input to output runs through two stages for input capture and range
// reduction, ten stages of the polynomial (nine with one multiplier each, then rounding
// and saturation), and the output register.
// A new request is taken every cycle; the whole pipeline holds while both entries of
// the output buffer are full, and in_tready is low exactly while it holds; it falls in
// the cycle after a result meets a stalled output.
module taylor_sine_cosine_unit
  import tsc_pkg::*;
#(
  parameter int FRAC_BITS      = TSC_FRAC_BITS,
  parameter int ANGLE_INT_BITS = TSC_ANGLE_INT_BITS,
  localparam int AW     = 1 + ANGLE_INT_BITS + FRAC_BITS,
  localparam int OW     = FRAC_BITS + 2,
  localparam int IN_DW  = ((AW + 7) / 8) * 8,
  localparam int OUT_DW = ((OW + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // angle
  input  logic              in_tuser,   // kind (0 sine, 1 cosine)
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata   // value
);

  localparam int XFW = FRAC_BITS + 3;

  logic                  en;
  logic                  wv;
  logic signed [XFW-1:0] wx;
  logic                  pv;
  logic signed [OW-1:0]  pval;
  logic [OW-1:0]         oval;

  tsc_wrap #(
    .FRAC_BITS      (FRAC_BITS),
    .ANGLE_INT_BITS (ANGLE_INT_BITS)
  ) u_wrap (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_kind   (in_tuser),
    .in_angle  (signed'(in_tdata[AW-1:0])),
    .out_valid (wv),
    .out_x     (wx)
  );

  tsc_poly #(
    .FRAC_BITS (FRAC_BITS)
  ) u_poly (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (wv),
    .in_x      (wx),
    .out_valid (pv),
    .out_value (pval)
  );

  tsc_skid #(
    .W (OW)
  ) u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pv),
    .in_data   (pval),
    .in_ready  (en),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (oval)
  );

  assign in_tready = en;
  assign out_tdata = OUT_DW'(oval);

endmodule

>>> hw/rtl/tsc_checker.sv
module tsc_checker
  import tsc_pkg::*;
#(
  parameter int FRAC_BITS = TSC_FRAC_BITS,
  localparam int OUT_DW = ((FRAC_BITS + 2 + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata
);

  localparam int CNTW = $clog2(TSC_DEPTH + 1) + 1;

  logic [CNTW-1:0] cnt_r;
  logic [CNTW-1:0] cnt_nxt;

  // requests inside the block
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_tvalid && in_tready) begin
      cnt_nxt = cnt_nxt + CNTW'(1);
    end
    if (out_tvalid && out_tready) begin
      cnt_nxt = cnt_nxt - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not empty after reset");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(TSC_DEPTH))
    else $error("more requests held than the pipeline can store");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cnt_r != '0)
    else $error("result shown with no request outstanding");

  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("input stalled without an output stall");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

endmodule

bind taylor_sine_cosine_unit tsc_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_tsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tsc_pkg::*;

  localparam int FB     = TSC_FRAC_BITS;
  localparam int ANG_W  = 1 + TSC_ANGLE_INT_BITS + FB;
  localparam int VAL_W  = FB + 2;
  localparam int IN_DW  = ((ANG_W + 7) / 8) * 8;
  localparam int OUT_DW = ((VAL_W + 7) / 8) * 8;

  // horner datapath precision
  localparam int     HW_FRAC  = 28;
  localparam longint HW_ONE   = 64'sd1 <<< HW_FRAC;
  localparam longint PI_BITS  = 64'sd3622009729038561421;  // pi at 60 fraction bits
  localparam longint ANG_PI   = (PI_BITS + (64'sd1 <<< (59 - FB))) >>> (60 - FB);
  localparam longint ANG_TAU  = (PI_BITS + (64'sd1 <<< (58 - FB))) >>> (59 - FB);
  localparam longint ANG_HALF = (PI_BITS + (64'sd1 <<< (60 - FB))) >>> (61 - FB);
  localparam longint INV72    = (HW_ONE + 36) / 72;
  localparam longint INV42    = (HW_ONE + 21) / 42;
  localparam longint INV20    = (HW_ONE + 10) / 20;
  localparam longint INV6     = (HW_ONE + 3) / 6;
  localparam longint VAL_MAX  = (64'sd1 <<< (FB + 1)) - 1;
  localparam longint VAL_MIN  = -(64'sd1 <<< (FB + 1));
  localparam longint ANG_MAX  = (64'sd1 <<< (ANG_W - 1)) - 1;
  localparam longint ANG_MIN  = -(64'sd1 <<< (ANG_W - 1));
  localparam int     DRAIN_CYCLES = 4 * TSC_DEPTH;
  localparam int     CYCLE_LIMIT  = 200000;

  typedef enum logic {
    KIND_SINE   = 1'b0,
    KIND_COSINE = 1'b1
  } wave_kind_e;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata   = '0;   // angle
  logic              in_tuser   = 1'b0; // kind (0 sine, 1 cosine)
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;         // value

  logic signed [VAL_W-1:0] expected_values[$];
  int                      error_count   = 0;
  int                      cycle_count   = 0;
  int                      send_idle_pct = 0;
  int                      recv_idle_pct = 0;

  taylor_sine_cosine_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shift right with rounding to nearest, ties away from zero
  function automatic longint round_away(input longint p, input int sh);
    longint m;
    m = (p < 0) ? -p : p;
    m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
    return (p < 0) ? -m : m;
  endfunction

  function automatic longint hw_mul(input longint a, input longint b);
    return round_away(a * b, HW_FRAC);
  endfunction

  function automatic logic signed [VAL_W-1:0] taylor_value(input wave_kind_e kind,
                                                           input logic signed [ANG_W-1:0] angle);
    longint x;
    longint x2;
    longint t;
    longint r;
    x = angle;
    if (kind == KIND_COSINE) begin
      x += ANG_HALF;
    end
    while (x > ANG_PI) x -= ANG_TAU;
    while (x < -ANG_PI) x += ANG_TAU;
    x = x <<< (HW_FRAC - FB);
    x2 = hw_mul(x, x);
    t = HW_ONE - hw_mul(x2, INV72);
    t = HW_ONE - hw_mul(hw_mul(x2, t), INV42);
    t = HW_ONE - hw_mul(hw_mul(x2, t), INV20);
    t = HW_ONE - hw_mul(hw_mul(x2, t), INV6);
    r = round_away(hw_mul(x, t), HW_FRAC - FB);
    if (r > VAL_MAX) r = VAL_MAX;
    if (r < VAL_MIN) r = VAL_MIN;
    return r[VAL_W-1:0];
  endfunction

  // holds the request on the bus until the block takes it
  task automatic send_request(input wave_kind_e kind, input longint angle);
    logic signed [ANG_W-1:0] a;
    a = angle[ANG_W-1:0];
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DW - ANG_W){1'b0}}, a};
    in_tuser  <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_values.push_back(taylor_value(kind, a));
  endtask

  task automatic test_corner_angles();
    longint corners[12];
    corners = '{ANG_MIN, ANG_MAX, 0, 1, -1, ANG_PI, -ANG_PI, ANG_PI + 1, -ANG_PI - 1,
                ANG_HALF, ANG_PI - ANG_HALF, -ANG_PI - ANG_HALF - 1};
    foreach (corners[i]) begin
      send_request(KIND_SINE, corners[i]);
      send_request(KIND_COSINE, corners[i]);
    end
  endtask

  task automatic test_random_angles(input int count);
    longint     angle;
    wave_kind_e kind;
    int         pick;
    repeat (count) begin
      kind = wave_kind_e'($urandom_range(1));
      pick = $urandom_range(9);
      if (pick < 4) begin
        angle = ANG_MIN + longint'($urandom_range(2 ** ANG_W - 1));
      end else if (pick < 7) begin
        // close to a wrap point, with or without the quarter turn
        angle = ((pick == 4) ? ANG_PI : -ANG_PI) + longint'($urandom_range(16)) - 8;
        if (kind == KIND_COSINE) angle -= ANG_HALF;
        if ($urandom_range(1)) angle += ANG_TAU * longint'($urandom_range(2));
      end else begin
        angle = longint'($urandom_range(2 * ANG_PI)) - ANG_PI;
      end
      if (angle > ANG_MAX) angle = ANG_MAX;
      if (angle < ANG_MIN) angle = ANG_MIN;
      send_request(kind, angle);
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    logic signed [VAL_W-1:0] want;
    logic signed [VAL_W-1:0] got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[VAL_W-1:0];
      if (expected_values.size() == 0) begin
        $error("value: unexpected result %0d", got);
        error_count++;
      end else begin
        want = expected_values.pop_front();
        if (got !== want) begin
          $error("value: expected %0d, actual %0d", want, got);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    send_idle_pct = 7;
    recv_idle_pct = 46;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_angles();
    test_random_angles(340);
    send_idle_pct = 46;
    recv_idle_pct = 7;
    test_random_angles(340);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_angles(345);
    in_tvalid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> taylor_sine_cosine_unit.f
hw/rtl/tsc_pkg.sv
hw/rtl/tsc_wrap.sv
hw/rtl/tsc_poly.sv
hw/rtl/tsc_skid.sv
hw/rtl/taylor_sine_cosine_unit.sv
hw/rtl/tsc_checker.sv
verif/testbench.sv
